@@ src/vtts_pkg.sv @@
// Package for the virtual-time task scheduler: sizes, opcodes, status codes,
// sequencer states and the saturating due-time add. No dependencies.
package vtts_pkg;

  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned IDX_BITS   = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_BITS   = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CLK_BITS   = 48;

  typedef enum logic [1:0] {
    OP_POST_IMM = 2'd0,
    OP_POST_DLY = 2'd1,
    OP_CANCEL   = 2'd2,
    OP_STEP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_READ,
    S_UPDATE,
    S_OUT
  } state_e;

  // Scan control from the sequencer to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic last;
  } scan_ctl_t;

  function automatic logic [CLK_BITS-1:0] sat_add48(input logic [CLK_BITS-1:0] a,
                                                    input logic [31:0] b);
    logic [CLK_BITS:0] s;
    s = {1'b0, a} + {{(CLK_BITS-31){1'b0}}, b};
    return s[CLK_BITS] ? {CLK_BITS{1'b1}} : s[CLK_BITS-1:0];
  endfunction

endpackage

@@ src/vtts_seq.sv @@
// Sequencer for the scheduler: walks the slot index one slot per cycle.
// Depends on vtts_pkg.
module vtts_seq (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic                     need_scan_i,
  input  logic [vtts_pkg::CNT_BITS-1:0] fill_i,
  input  logic                     out_taken_i,
  output vtts_pkg::state_e         state_o,
  output vtts_pkg::scan_ctl_t      ctl_o,
  output logic [vtts_pkg::IDX_BITS-1:0] idx_o
);
  import vtts_pkg::*;

  state_e state_q, state_d;
  logic [CNT_BITS-1:0] idx_q, idx_d;

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (go_i) begin
          if (need_scan_i && fill_i != '0) state_d = S_SCAN;
          else if (need_scan_i) state_d = S_RESOLVE;
          else state_d = S_UPDATE;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 == fill_i) state_d = S_DRAIN;
      end
      // last slot's read data goes through the compare unit
      S_DRAIN:   state_d = S_RESOLVE;
      S_RESOLVE: state_d = S_READ;
      S_READ:    state_d = S_UPDATE;
      S_UPDATE:  state_d = S_OUT;
      S_OUT:     if (out_taken_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl_o.start = (state_q == S_IDLE) && go_i;
    ctl_o.scan  = (state_q == S_SCAN);
    ctl_o.last  = (state_q == S_SCAN) && (idx_q + 1'b1 == fill_i);
  end

  assign state_o = state_q;
  assign idx_o   = idx_q[IDX_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule

@@ src/virtual_time_task_scheduler.sv @@
// Top level of the virtual-time task scheduler: slot memories, shared
// compare unit and result register. Depends on vtts_pkg and vtts_seq.
//
// Each item is one operation. Posts pass through the update state and the
// result state, plus any output stall; step and cancel scan every filled
// slot, one per cycle through the shared compare unit, then pass through
// the drain (only after a scan), resolve, read, update and result states. The
// input is stalled while an item is in work or its result waits. No clearing
// pass: live bits are flip-flops cleared by reset.
module virtual_time_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] task_tag_i,
  input  logic [31:0] delay_ms_i,
  input  logic        repeating_i,
  input  logic [31:0] cancel_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] new_timer_id_o,
  output logic [15:0] run_tag_o,
  output logic [47:0] clock_now_o,
  output logic [31:0] dropped_total_o
);
  import vtts_pkg::*;

  // slot memories
  logic [TAG_BITS-1:0] tag_mem [SLOT_COUNT];
  logic [CLK_BITS-1:0] due_mem [SLOT_COUNT];
  logic [31:0]         per_mem [SLOT_COUNT];
  logic [31:0]         id_mem  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] live_q;

  logic [CNT_BITS-1:0] fill_q;
  logic [CLK_BITS-1:0] clock_q;
  logic [31:0]         last_id_q, drop_q;

  // latched item
  logic [1:0]  op_q;
  logic [15:0] tag_q;
  logic [31:0] delay_q, cid_q;
  logic        rep_q;

  // scan state
  logic                imm_found_q, tmr_found_q;
  logic [IDX_BITS-1:0] imm_idx_q, tmr_idx_q, pick_q;
  logic [CLK_BITS-1:0] best_due_q;
  logic                pick_ok_q, pick_imm_q;

  // registered read data
  logic [TAG_BITS-1:0] rd_tag_q;
  logic [CLK_BITS-1:0] rd_due_q;
  logic [31:0]         rd_per_q, rd_id_q;

  // result register
  logic [1:0]  status_q;
  logic [31:0] new_id_q;
  logic [15:0] run_q;

  state_e              state;
  scan_ctl_t           ctl;
  logic [IDX_BITS-1:0] idx;
  logic                go, need_scan;

  assign in_stall_o = (state != S_IDLE);
  assign go         = in_valid_i && !in_stall_o;
  assign need_scan  = (opcode_i == OP_CANCEL) || (opcode_i == OP_STEP);

  vtts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .need_scan_i (need_scan),
    .fill_i      (fill_q),
    .out_taken_i (!out_stall_i),
    .state_o     (state),
    .ctl_o       (ctl),
    .idx_o       (idx)
  );

  // read address: scan index, then the picked slot
  logic [IDX_BITS-1:0] raddr;
  assign raddr = (state == S_SCAN) ? idx : pick_q;

  always_ff @(posedge clk_i) begin
    rd_tag_q <= tag_mem[raddr];
    rd_due_q <= due_mem[raddr];
    rd_per_q <= per_mem[raddr];
    rd_id_q  <= id_mem[raddr];
  end

  // scan pipeline: read data arrives in the cycle after its index
  logic                scan_v_q;
  logic [IDX_BITS-1:0] scan_idx_q;
  logic                live_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_v_q <= 1'b0;
    end else begin
      scan_v_q <= ctl.scan;
    end
  end
  always_ff @(posedge clk_i) begin
    scan_idx_q <= idx;
    live_rd_q  <= live_q[idx];
  end

  // shared compare unit
  logic id_hit, due_less;
  logic [31:0] match_id;
  assign match_id = (op_q == OP_CANCEL) ? cid_q : 32'd0;
  assign id_hit   = live_rd_q && (rd_id_q == match_id);
  assign due_less = rd_due_q < best_due_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_found_q <= 1'b0;
      tmr_found_q <= 1'b0;
    end else if (ctl.start) begin
      imm_found_q <= 1'b0;
      tmr_found_q <= 1'b0;
    end else if (scan_v_q) begin
      if (id_hit && !imm_found_q) imm_found_q <= 1'b1;
      if (live_rd_q && (!tmr_found_q || due_less)) tmr_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_v_q) begin
      if (id_hit && !imm_found_q) imm_idx_q <= scan_idx_q;
      if (live_rd_q && (!tmr_found_q || due_less)) begin
        tmr_idx_q  <= scan_idx_q;
        best_due_q <= rd_due_q;
      end
    end
  end

  // pick resolve (in the cycle after the last read lands)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_ok_q  <= 1'b0;
      pick_imm_q <= 1'b0;
    end else if (state == S_RESOLVE) begin
      pick_imm_q <= imm_found_q;
      pick_ok_q  <= imm_found_q || (op_q == OP_STEP && tmr_found_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (state == S_RESOLVE) pick_q <= imm_found_q ? imm_idx_q : tmr_idx_q;
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (go) begin
      op_q    <= opcode_i;
      tag_q   <= task_tag_i;
      delay_q <= delay_ms_i;
      rep_q   <= repeating_i;
      cid_q   <= cancel_id_i;
    end
  end

  // update step
  logic                full, do_append, do_rearm;
  logic [IDX_BITS-1:0] wr_idx;
  logic [CLK_BITS-1:0] wr_due, new_clock;
  logic [31:0]         wr_per, wr_id;
  logic [TAG_BITS-1:0] wr_tag;

  assign full = (fill_q == CNT_BITS'(SLOT_COUNT));
  assign new_clock = (rd_due_q > clock_q) ? rd_due_q : clock_q;

  always_comb begin
    do_append = 1'b0;
    do_rearm  = 1'b0;
    wr_idx    = fill_q[IDX_BITS-1:0];
    wr_tag    = tag_q[TAG_BITS-1:0];
    wr_due    = '0;
    wr_per    = '0;
    wr_id     = '0;
    if (state == S_UPDATE) begin
      case (op_q)
        OP_POST_IMM: do_append = !full;
        OP_POST_DLY: begin
          do_append = !full;
          wr_due    = sat_add48(clock_q, delay_q);
          wr_per    = rep_q ? delay_q : 32'd0;
          wr_id     = last_id_q + 32'd1;
        end
        OP_STEP: begin
          if (pick_ok_q && rd_per_q != 32'd0) begin
            do_rearm = 1'b1;
            wr_idx   = pick_q;
            wr_due   = sat_add48(pick_imm_q ? clock_q : new_clock, rd_per_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      tag_mem[wr_idx] <= wr_tag;
      per_mem[wr_idx] <= wr_per;
      id_mem[wr_idx]  <= wr_id;
    end
    if (do_append || do_rearm) due_mem[wr_idx] <= wr_due;
  end

  // control state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      fill_q    <= '0;
      clock_q   <= '0;
      last_id_q <= '0;
      drop_q    <= '0;
      status_q  <= ST_DONE;
      new_id_q  <= '0;
      run_q     <= '0;
    end else if (state == S_UPDATE) begin
      status_q <= ST_DONE;
      new_id_q <= '0;
      run_q    <= '0;
      case (op_q)
        OP_POST_IMM, OP_POST_DLY: begin
          if (full) begin
            status_q <= ST_FULL;
          end else begin
            live_q[wr_idx] <= 1'b1;
            fill_q <= fill_q + 1'b1;
            if (op_q == OP_POST_DLY) begin
              last_id_q <= wr_id;
              new_id_q  <= wr_id;
            end
          end
        end
        OP_CANCEL: begin
          if (pick_ok_q) begin
            live_q[pick_q] <= 1'b0;
            if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
          end else begin
            status_q <= ST_NOMATCH;
          end
        end
        default: begin
          if (pick_ok_q) begin
            run_q <= 16'(rd_tag_q);
            if (!pick_imm_q) clock_q <= new_clock;
            if (rd_per_q == 32'd0) live_q[pick_q] <= 1'b0;
          end else begin
            status_q <= ST_EMPTY;
          end
        end
      endcase
    end
  end

  assign out_valid_o     = (state == S_OUT);
  assign status_o        = status_q;
  assign new_timer_id_o  = new_id_q;
  assign run_tag_o       = run_q;
  assign clock_now_o     = clock_q;
  assign dropped_total_o = drop_q;

  logic unused;
  assign unused = ctl.last ^ (|rd_id_q[0]);
endmodule

@@ bench/virtual_time_task_scheduler_tb.sv @@
// Testbench for virtual_time_task_scheduler: directed and random operation
// streams, checked against an in-bench scheduler predictor. Depends on vtts_pkg and virtual_time_task_scheduler.
`timescale 1ns / 1ps

module virtual_time_task_scheduler_tb;
  import vtts_pkg::*;

  typedef struct {
    status_e     status;
    logic [31:0] new_id;
    logic [15:0] run_tag;
    logic [47:0] clock_now;
    logic [31:0] drops;
  } sched_result_t;

  // Predictor of the slot table plus the queue of results it expects
  class sched_scoreboard;
    logic [15:0]   tag_mem[SLOT_COUNT];
    logic [47:0]   due_mem[SLOT_COUNT];
    logic [31:0]   period_mem[SLOT_COUNT];
    logic [31:0]   id_mem[SLOT_COUNT];
    bit            live_mem[SLOT_COUNT];
    int unsigned   used;
    logic [47:0]   now_ms;
    logic [31:0]   id_counter;
    logic [31:0]   cancelled;
    sched_result_t due_results[$];
    int            errors;

    function new();
      foreach (live_mem[i]) live_mem[i] = 1'b0;
      used = 0;
      now_ms = '0;
      id_counter = '0;
      cancelled = '0;
      errors = 0;
    endfunction

    // 48-bit add that sticks at all ones
    function logic [47:0] due_sum(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function void add_slot(logic [15:0] tag, logic [47:0] due, logic [31:0] period,
                           logic [31:0] id);
      tag_mem[used] = tag;
      due_mem[used] = due;
      period_mem[used] = period;
      id_mem[used] = id;
      live_mem[used] = 1'b1;
      used++;
    endfunction

    // Apply one accepted item and queue its result
    function void note_item(opcode_e op, logic [15:0] tag, logic [31:0] delay,
                            logic rep, logic [31:0] cid);
      sched_result_t r;
      int pick;
      r.status = ST_DONE;
      r.new_id = '0;
      r.run_tag = '0;
      pick = -1;
      case (op)
        OP_POST_IMM: begin
          if (used >= SLOT_COUNT) r.status = ST_FULL;
          else add_slot(tag, '0, '0, '0);
        end
        OP_POST_DLY: begin
          if (used >= SLOT_COUNT) r.status = ST_FULL;
          else begin
            id_counter++;
            add_slot(tag, due_sum(now_ms, delay), rep ? delay : 32'd0, id_counter);
            r.new_id = id_counter;
          end
        end
        OP_CANCEL: begin
          r.status = ST_NOMATCH;
          for (int i = 0; i < used; i++) begin
            if (live_mem[i] && id_mem[i] == cid) begin
              live_mem[i] = 1'b0;
              if (cancelled != 32'hFFFF_FFFF) cancelled++;
              r.status = ST_DONE;
              break;
            end
          end
        end
        default: begin
          // immediates first, lowest index
          for (int i = 0; i < used; i++) begin
            if (live_mem[i] && id_mem[i] == 32'd0) begin
              pick = i;
              break;
            end
          end
          // else earliest due, ties to lowest index
          if (pick < 0) begin
            for (int i = 0; i < used; i++)
              if (live_mem[i] && (pick < 0 || due_mem[i] < due_mem[pick])) pick = i;
            if (pick >= 0 && due_mem[pick] > now_ms) now_ms = due_mem[pick];
          end
          if (pick < 0) r.status = ST_EMPTY;
          else begin
            r.run_tag = tag_mem[pick];
            if (period_mem[pick] != 0) due_mem[pick] = due_sum(now_ms, period_mem[pick]);
            else live_mem[pick] = 1'b0;
          end
        end
      endcase
      r.clock_now = now_ms;
      r.drops = cancelled;
      due_results.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, field, got, want);
    endtask

    task check_result(sched_result_t got);
      sched_result_t w;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result, status %0d", $realtime, got.status);
      end else begin
        w = due_results.pop_front();
        if (got.status !== w.status) report("status", got.status, w.status);
        if (got.new_id !== w.new_id) report("new_timer_id", got.new_id, w.new_id);
        if (got.run_tag !== w.run_tag) report("run_tag", got.run_tag, w.run_tag);
        if (got.clock_now !== w.clock_now) report("clock_now", got.clock_now, w.clock_now);
        if (got.drops !== w.drops) report("dropped_total", got.drops, w.drops);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = '0;
  logic [15:0] task_tag_i = '0;
  logic [31:0] delay_ms_i = '0;
  logic        repeating_i = 1'b0;
  logic [31:0] cancel_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] new_timer_id_o;
  logic [15:0] run_tag_o;
  logic [47:0] clock_now_o;
  logic [31:0] dropped_total_o;

  sched_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off = 0;
  int unsigned posted = 0;
  int unsigned ids_given = 0;

  virtual_time_task_scheduler uut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver stall: long hold-off when requested, otherwise random
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_stall_i = 1'b1;
        hold_off--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    sched_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_e'(status_o);
      got.new_id = new_timer_id_o;
      got.run_tag = run_tag_o;
      got.clock_now = clock_now_o;
      got.drops = dropped_total_o;
      sb.check_result(got);
    end
  end

  // Offer one item, wait for acceptance; called at a falling edge
  task send_item(opcode_e op, logic [15:0] tag, logic [31:0] delay, logic rep,
                 logic [31:0] cid);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    task_tag_i = tag;
    delay_ms_i = delay;
    repeating_i = rep;
    cancel_id_i = cid;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, tag, delay, rep, cid);
    if (op == OP_POST_IMM || op == OP_POST_DLY) begin
      if (posted < SLOT_COUNT) begin
        posted++;
        if (op == OP_POST_DLY) ids_given++;
      end
    end
    @(negedge clk_i);
  endtask

  // Random item with weights that fill the table gradually
  task send_random();
    int unsigned pick;
    logic [31:0] delay;
    logic [31:0] cid;
    opcode_e op;
    pick = $urandom_range(99);
    if (posted < SLOT_COUNT)
      op = pick < 20 ? OP_POST_IMM : pick < 45 ? OP_POST_DLY : pick < 65 ? OP_CANCEL : OP_STEP;
    else
      op = pick < 3 ? OP_POST_IMM : pick < 6 ? OP_POST_DLY : pick < 35 ? OP_CANCEL : OP_STEP;
    pick = $urandom_range(99);
    delay = pick < 20 ? 32'd0 : pick < 80 ? $urandom_range(50) : $urandom;
    pick = $urandom_range(99);
    if (pick < 45 && ids_given > 0) cid = $urandom_range(ids_given, 1);
    else if (pick < 65) cid = 32'd0;
    else if (pick < 85) cid = $urandom;
    else cid = ids_given + $urandom_range(3, 1);
    send_item(op, $urandom, delay, $urandom_range(1), cid);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, field extremes, each operation and corner
    send_item(OP_STEP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_POST_IMM, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_POST_IMM, 16'hFFFF, 32'h0, 1'b0, 32'h0);
    send_item(OP_POST_DLY, 16'h1234, 32'd0, 1'b1, 32'h0);
    send_item(OP_POST_DLY, 16'hABCD, 32'hFFFF_FFFF, 1'b1, 32'h0);
    send_item(OP_POST_DLY, 16'h5555, 32'd5, 1'b0, 32'h0);
    send_item(OP_POST_DLY, 16'hAAAA, 32'd5, 1'b0, 32'h0);
    send_item(OP_POST_DLY, 16'h0F0F, 32'd7, 1'b1, 32'h0);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'd4);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'd5);
    send_item(OP_CANCEL, 16'h0, 32'h0, 1'b0, 32'd5);
    send_item(OP_STEP, 16'h0, 32'h0, 1'b0, 32'h0);

    // Random phases with different idle mixes
    send_idle_pct = 29;
    recv_idle_pct = 87;
    repeat (484) send_random();
    send_idle_pct = 87;
    recv_idle_pct = 29;
    repeat (484) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 600;
    repeat (482) send_random();
    in_valid_i = 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
